// ----- rtl/pfqr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfqr_pkg: shared types and constants for the quarter-turn frame rotator
// Holds controller states, plane and rotation codes, register indexes and the
// command/status bundles exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package pfqr_pkg;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DIM_LIMIT = 9'd511;
    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TURNS = 2'd2;

    // rotation codes
    localparam logic [1:0] TURN_0   = 2'd0;
    localparam logic [1:0] TURN_90  = 2'd1;
    localparam logic [1:0] TURN_180 = 2'd2;
    localparam logic [1:0] TURN_270 = 2'd3;

    typedef enum logic [1:0] {
        PLANE_Y,
        PLANE_CB,
        PLANE_CR
    } plane_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_CALC,
        ST_ACCESS,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic take;
        logic check;
        logic div_start;
        logic calc;
        logic access;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic wrap;
        logic dirty;
        logic div_done;
        logic have_frame;
        logic out_free;
    } ctrl_stat_t;

    // clamp to [2, cap], then round down to even
    function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] r;
        r = v;
        if (r > cap) begin
            r = cap;
        end
        if (r < 9'd2) begin
            r = 9'd2;
        end
        return {r[DIM_W-1:1], 1'b0};
    endfunction

endpackage

// ----- rtl/pfqr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfqr_div: restoring divider, one quotient bit per cycle
// Splits a plane offset into row (quotient) and column (remainder) for a
// divisor of up to nine bits.
// ----------------------------------------------------------------------------
module pfqr_div #(
    parameter int DW = 17
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [DW-1:0]               dividend,
    input  logic [pfqr_pkg::DIM_W-1:0]  divisor,
    output logic                        done,
    output logic [DW-1:0]               quotient,
    output logic [pfqr_pkg::DIM_W-1:0]  remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]              quot_reg, quot_next;
    logic [pfqr_pkg::DIM_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [pfqr_pkg::DIM_W:0]   trial;

    always_comb begin
        trial      = {rem_reg, quot_reg[DW-1]};
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            quot_next  = dividend;
            rem_next   = '0;
            count_next = CW'(DW);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next  = pfqr_pkg::DIM_W'(trial - {1'b0, divisor});
                quot_next = {quot_reg[DW-2:0], 1'b1};
            end else begin
                rem_next  = trial[pfqr_pkg::DIM_W-1:0];
                quot_next = {quot_reg[DW-2:0], 1'b0};
            end
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/pfqr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfqr_dp: rotator datapath
// Configuration registers, frame position and rotated-raster counters, the
// two-bank frame store, the rotated address unit and the output register.
// ----------------------------------------------------------------------------
module pfqr_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pfqr_pkg::ctrl_cmd_t             cmd,
    output pfqr_pkg::ctrl_stat_t            stat,
    input  logic [pfqr_pkg::PIX_W-1:0]      s_pixel_in,
    input  logic                            cfg_valid,
    input  logic [pfqr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfqr_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [pfqr_pkg::PIX_W-1:0]      m_pixel_out,
    output logic                            m_frame_end,
    output logic [pfqr_pkg::DIM_W-1:0]      m_rotated_width,
    output logic [pfqr_pkg::DIM_W-1:0]      m_rotated_height
);

    localparam int BANK_SIZE = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
    localparam int PW = $clog2(BANK_SIZE + 1);
    localparam int AW = $clog2(BANK_SIZE);
    localparam int DW = pfqr_pkg::DIM_W;
    localparam int PIX_W_L = pfqr_pkg::PIX_W;
    localparam logic [DW-1:0] W_CAP =
        (MAX_WIDTH > 511) ? pfqr_pkg::DIM_LIMIT : DW'(MAX_WIDTH);
    localparam logic [DW-1:0] H_CAP =
        (MAX_HEIGHT > 511) ? pfqr_pkg::DIM_LIMIT : DW'(MAX_HEIGHT);

    // configuration
    logic [DW-1:0] cfg_width_reg, cfg_height_reg;
    logic [1:0]    cfg_turns_reg;
    logic [DW-1:0] iw, ih, iw_half, ih_half;
    logic [2*DW-1:0] lsz_full;
    logic [2*DW-3:0] csz_full;
    logic [PW-1:0] lsz_reg, csz_reg;

    // frame position and rotated raster counters
    logic [PW-1:0]  pos_reg, size_reg, cr_base_reg;
    logic           bank_reg, have_reg, dirty_reg;
    pfqr_pkg::plane_t plane_reg;
    logic [DW-1:0]  ox_reg, oy_reg;

    // per-item pipeline
    logic [PIX_W_L-1:0] pixel_reg;
    logic [2*DW-1:0]    prod_reg;
    logic [PW-1:0]      basec_reg;
    logic [PIX_W_L-1:0] rd0_reg, rd1_reg;
    logic               out_bank_reg, have_snap_reg, frame_end_reg;

    // output register
    logic                m_valid_reg;
    logic [PIX_W_L-1:0]  m_pixel_reg;
    logic                m_frame_end_reg;
    logic [DW-1:0]       m_rot_w_reg, m_rot_h_reg;

    // frame store banks
    logic [PIX_W_L-1:0] bank0_mem [BANK_SIZE];
    logic [PIX_W_L-1:0] bank1_mem [BANK_SIZE];

    // combinational helpers
    logic [PW-1:0]     size_c, cr_base_c, p_c, src_c, pos_inc;
    logic              wrap_c, last_c;
    pfqr_pkg::plane_t  plane_c;
    logic [DW-1:0]     pw_c, ph_c, div_ow;
    logic [DW-1:0]     pw_cur, ph_cur, ow_cur, oh_cur;
    logic [DW-1:0]     r_c, c_c, ox_inc, oy_inc;
    logic [PW-1:0]     base_c;
    logic              div_done;
    logic [PW-1:0]     div_quot;
    logic [DW-1:0]     div_rem;

    function automatic pfqr_pkg::plane_t next_plane(input pfqr_pkg::plane_t p);
        pfqr_pkg::plane_t n;
        unique case (p)
            pfqr_pkg::PLANE_Y:  n = pfqr_pkg::PLANE_CB;
            pfqr_pkg::PLANE_CB: n = pfqr_pkg::PLANE_CR;
            default:            n = pfqr_pkg::PLANE_Y;
        endcase
        return n;
    endfunction

    assign iw       = pfqr_pkg::fit_dim(cfg_width_reg, W_CAP);
    assign ih       = pfqr_pkg::fit_dim(cfg_height_reg, H_CAP);
    assign iw_half  = {1'b0, iw[DW-1:1]};
    assign ih_half  = {1'b0, ih[DW-1:1]};
    assign lsz_full = iw * ih;
    assign csz_full = iw_half[DW-2:0] * ih_half[DW-2:0];

    // frame size check and plane lookup for counter resync
    always_comb begin
        size_c    = lsz_reg + (csz_reg << 1);
        cr_base_c = lsz_reg + csz_reg;
        wrap_c    = (pos_reg >= size_c);
        if (pos_reg < lsz_reg) begin
            plane_c = pfqr_pkg::PLANE_Y;
            p_c     = pos_reg;
        end else if (pos_reg < cr_base_c) begin
            plane_c = pfqr_pkg::PLANE_CB;
            p_c     = pos_reg - lsz_reg;
        end else begin
            plane_c = pfqr_pkg::PLANE_CR;
            p_c     = pos_reg - cr_base_c;
        end
        pw_c   = (plane_c == pfqr_pkg::PLANE_Y) ? iw : iw_half;
        ph_c   = (plane_c == pfqr_pkg::PLANE_Y) ? ih : ih_half;
        div_ow = cfg_turns_reg[0] ? ph_c : pw_c;
    end

    // rotated source coordinates of the current output byte
    always_comb begin
        pw_cur = (plane_reg == pfqr_pkg::PLANE_Y) ? iw : iw_half;
        ph_cur = (plane_reg == pfqr_pkg::PLANE_Y) ? ih : ih_half;
        ow_cur = cfg_turns_reg[0] ? ph_cur : pw_cur;
        oh_cur = cfg_turns_reg[0] ? pw_cur : ph_cur;
        unique case (cfg_turns_reg)
            pfqr_pkg::TURN_0: begin
                r_c = oy_reg;
                c_c = ox_reg;
            end
            pfqr_pkg::TURN_90: begin
                r_c = ph_cur - ox_reg - DW'(1);
                c_c = oy_reg;
            end
            pfqr_pkg::TURN_180: begin
                r_c = ph_cur - oy_reg - DW'(1);
                c_c = pw_cur - ox_reg - DW'(1);
            end
            default: begin
                r_c = ox_reg;
                c_c = pw_cur - oy_reg - DW'(1);
            end
        endcase
        unique case (plane_reg)
            pfqr_pkg::PLANE_Y:  base_c = '0;
            pfqr_pkg::PLANE_CB: base_c = lsz_reg;
            default:            base_c = cr_base_reg;
        endcase
        src_c   = PW'(prod_reg) + basec_reg;
        pos_inc = pos_reg + PW'(1);
        last_c  = (pos_inc == size_reg);
        ox_inc  = ox_reg + DW'(1);
        oy_inc  = oy_reg + DW'(1);
    end

    pfqr_div #(
        .DW(PW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (p_c),
        .divisor  (div_ow),
        .done     (div_done),
        .quotient (div_quot),
        .remainder(div_rem)
    );

    // configuration registers and derived plane sizes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= pfqr_pkg::DIM_RESET;
            cfg_height_reg <= pfqr_pkg::DIM_RESET;
            cfg_turns_reg  <= pfqr_pkg::TURN_0;
        end else if (cfg_valid) begin
            case (cfg_index)
                pfqr_pkg::REG_FRAME_WIDTH:   cfg_width_reg  <= cfg_data;
                pfqr_pkg::REG_FRAME_HEIGHT:  cfg_height_reg <= cfg_data;
                pfqr_pkg::REG_QUARTER_TURNS: cfg_turns_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
        lsz_reg <= PW'(lsz_full);
        csz_reg <= PW'(csz_full);
    end

    // frame position, bank and rotated raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            bank_reg  <= 1'b0;
            have_reg  <= 1'b0;
            dirty_reg <= 1'b0;
            plane_reg <= pfqr_pkg::PLANE_Y;
            ox_reg    <= '0;
            oy_reg    <= '0;
        end else begin
            if (cmd.check && wrap_c) begin
                pos_reg   <= '0;
                plane_reg <= pfqr_pkg::PLANE_Y;
                ox_reg    <= '0;
                oy_reg    <= '0;
                dirty_reg <= 1'b0;
            end
            if (cmd.div_start) begin
                plane_reg <= plane_c;
            end
            if (div_done) begin
                ox_reg    <= div_rem;
                oy_reg    <= DW'(div_quot);
                dirty_reg <= 1'b0;
            end
            if (cmd.access) begin
                if (last_c) begin
                    pos_reg   <= '0;
                    bank_reg  <= ~bank_reg;
                    have_reg  <= 1'b1;
                    plane_reg <= pfqr_pkg::PLANE_Y;
                    ox_reg    <= '0;
                    oy_reg    <= '0;
                    dirty_reg <= 1'b0;
                end else begin
                    pos_reg <= pos_inc;
                    if (ox_inc == ow_cur) begin
                        ox_reg <= '0;
                        if (oy_inc == oh_cur) begin
                            oy_reg    <= '0;
                            plane_reg <= next_plane(plane_reg);
                        end else begin
                            oy_reg <= oy_inc;
                        end
                    end else begin
                        ox_reg <= ox_inc;
                    end
                end
            end
            if (cfg_valid) begin
                dirty_reg <= 1'b1;
            end
        end
    end

    // per-item payload stages
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pixel_reg <= s_pixel_in;
        end
        if (cmd.check) begin
            size_reg    <= size_c;
            cr_base_reg <= cr_base_c;
        end
        if (cmd.calc) begin
            prod_reg  <= r_c * pw_cur;
            basec_reg <= base_c + PW'(c_c);
        end
        if (cmd.access) begin
            out_bank_reg  <= ~bank_reg;
            have_snap_reg <= have_reg;
            frame_end_reg <= last_c;
        end
    end

    // frame store: write the loading bank, read both banks at the source
    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            if (!bank_reg) begin
                bank0_mem[pos_reg[AW-1:0]] <= pixel_reg;
            end
            rd0_reg <= bank0_mem[src_c[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            if (bank_reg) begin
                bank1_mem[pos_reg[AW-1:0]] <= pixel_reg;
            end
            rd1_reg <= bank1_mem[src_c[AW-1:0]];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_pixel_reg     <= out_bank_reg ? rd1_reg : rd0_reg;
            m_frame_end_reg <= frame_end_reg;
            m_rot_w_reg     <= cfg_turns_reg[0] ? ih : iw;
            m_rot_h_reg     <= cfg_turns_reg[0] ? iw : ih;
        end
    end

    assign stat.wrap       = wrap_c;
    assign stat.dirty      = dirty_reg;
    assign stat.div_done   = div_done;
    assign stat.have_frame = have_snap_reg;
    assign stat.out_free   = ~m_valid_reg | m_ready;

    assign m_valid          = m_valid_reg;
    assign m_pixel_out      = m_pixel_reg;
    assign m_frame_end      = m_frame_end_reg;
    assign m_rotated_width  = m_rot_w_reg;
    assign m_rotated_height = m_rot_h_reg;

endmodule

// ----- rtl/pfqr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfqr_ctrl: rotator sequencer
// Steps each input transaction through size check, optional counter resync,
// address calculation, store access and output load.
// ----------------------------------------------------------------------------
module pfqr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pfqr_pkg::ctrl_stat_t  stat,
    output pfqr_pkg::ctrl_cmd_t   cmd
);

    pfqr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfqr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfqr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pfqr_pkg::ST_CHECK;
                end
            end
            pfqr_pkg::ST_CHECK: begin
                if (!stat.wrap && stat.dirty) begin
                    state_next = pfqr_pkg::ST_DIVIDE;
                end else begin
                    state_next = pfqr_pkg::ST_CALC;
                end
            end
            pfqr_pkg::ST_DIVIDE: begin
                if (stat.div_done) begin
                    state_next = pfqr_pkg::ST_CALC;
                end
            end
            pfqr_pkg::ST_CALC:   state_next = pfqr_pkg::ST_ACCESS;
            pfqr_pkg::ST_ACCESS: state_next = pfqr_pkg::ST_OUTPUT;
            pfqr_pkg::ST_OUTPUT: begin
                if (!stat.have_frame || stat.out_free) begin
                    state_next = pfqr_pkg::ST_IDLE;
                end
            end
            default: state_next = pfqr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            pfqr_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            pfqr_pkg::ST_CHECK: begin
                cmd.check     = 1'b1;
                cmd.div_start = ~stat.wrap & stat.dirty;
            end
            pfqr_pkg::ST_DIVIDE: ;
            pfqr_pkg::ST_CALC:   cmd.calc   = 1'b1;
            pfqr_pkg::ST_ACCESS: cmd.access = 1'b1;
            pfqr_pkg::ST_OUTPUT: cmd.load_out = stat.have_frame & stat.out_free;
            default: ;
        endcase
    end

endmodule

// ----- rtl/planar_frame_quarter_rotate.sv -----
`timescale 1ns / 1ps
// Each accepted transaction passes through the controller's check, address
//   multiply, store access and output load states; a new transaction is taken
//   only once the previous one has left the output state, which can wait on a stalled sink.
// The first transaction after a configuration write adds the divider's
//   resync of the raster counters, unless the frame position has wrapped.
// Reset (aresetn low, synchronous) clears control state; the store is not cleared.
// ----------------------------------------------------------------------------
// planar_frame_quarter_rotate: quarter-turn rotator for planar 4:2:0 frames
// Loads raster bytes into one bank of a two-bank frame store while releasing
// the previous frame from the other bank in rotated raster order.
// ----------------------------------------------------------------------------
module planar_frame_quarter_rotate #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input byte stream
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pfqr_pkg::PIX_W-1:0]      s_pixel_in,
    // rotated byte stream
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pfqr_pkg::PIX_W-1:0]      m_pixel_out,
    output logic                            m_frame_end,
    output logic [pfqr_pkg::DIM_W-1:0]      m_rotated_width,
    output logic [pfqr_pkg::DIM_W-1:0]      m_rotated_height,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfqr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfqr_pkg::DIM_W-1:0]      cfg_data
);

    pfqr_pkg::ctrl_cmd_t  cmd;
    pfqr_pkg::ctrl_stat_t stat;

    // Registers take every write transaction at once.
    assign cfg_ready = 1'b1;

    // Sequence each input transaction: check the position against the
    // current frame size, resync the rotated counters after a register
    // change, form the source address, access the store, then load the
    // output register (held while the sink stalls).
    pfqr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold configuration, counters, both store banks and the output register.
    pfqr_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_pixel_in      (s_pixel_in),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_pixel_out     (m_pixel_out),
        .m_frame_end     (m_frame_end),
        .m_rotated_width (m_rotated_width),
        .m_rotated_height(m_rotated_height)
    );

endmodule
